>>> rtl/sip24_pkg.sv
// Shared types, constants and round functions for the SipHash-2-4 stream core.
package sip24_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned CountW = 4;
  localparam int unsigned LenW   = 8;
  localparam int unsigned AddrW  = 4;

  localparam logic [WordW-1:0] IV_A = 64'h736F6D6570736575;
  localparam logic [WordW-1:0] IV_B = 64'h646F72616E646F6D;
  localparam logic [WordW-1:0] IV_C = 64'h6C7967656E657261;
  localparam logic [WordW-1:0] IV_D = 64'h7465646279746573;
  localparam logic [WordW-1:0] FIN_XOR = 64'h00000000000000FF;

  // Register indexes, taken from address bit 3 (registers sit 8 bytes apart).
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
  } lanes_t;

  // A finished message handed from the absorb stage to finalization.
  typedef struct packed {
    lanes_t          lanes;
    logic            full_last;
    logic [LenW-1:0] len;
  } fin_t;

  function automatic lanes_t sip_round(lanes_t s);
    lanes_t r;
    r = s;
    r.a = r.a + r.b;  r.b = {r.b[50:0], r.b[63:51]};
    r.b = r.b ^ r.a;  r.a = {r.a[31:0], r.a[63:32]};
    r.c = r.c + r.d;  r.d = {r.d[47:0], r.d[63:48]};
    r.d = r.d ^ r.c;
    r.a = r.a + r.d;  r.d = {r.d[42:0], r.d[63:43]};
    r.d = r.d ^ r.a;
    r.c = r.c + r.b;  r.b = {r.b[46:0], r.b[63:47]};
    r.b = r.b ^ r.c;  r.c = {r.c[31:0], r.c[63:32]};
    return r;
  endfunction

  function automatic lanes_t sip_absorb(lanes_t s, logic [WordW-1:0] m);
    lanes_t r;
    r = s;
    r.d = r.d ^ m;
    r = sip_round(r);
    r = sip_round(r);
    r.a = r.a ^ m;
    return r;
  endfunction

endpackage

>>> rtl/sip24_cfg.sv
// APB-style key register file for the SipHash-2-4 stream core.
module sip24_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sip24_pkg::AddrW-1:0] paddr,
  input  logic [sip24_pkg::WordW-1:0] pwdata,
  output logic [sip24_pkg::WordW-1:0] prdata,
  output logic                      pready,
  output logic [sip24_pkg::WordW-1:0] key_low_o,
  output logic [sip24_pkg::WordW-1:0] key_high_o
);
  import sip24_pkg::*;

  logic [WordW-1:0] key_low_q;
  logic [WordW-1:0] key_high_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (wr_en) begin
      unique case (paddr[3])
        REG_KEY_LOW:  key_low_q  <= pwdata;
        REG_KEY_HIGH: key_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_KEY_LOW:  prdata = key_low_q;
      REG_KEY_HIGH: prdata = key_high_q;
      default:      prdata = '0;
    endcase
  end

  assign key_low_o  = key_low_q;
  assign key_high_o = key_high_q;

endmodule

>>> rtl/sip24_absorb.sv
// Input register and per-word compression loop (two SipRounds per word).
module sip24_absorb (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sip24_pkg::WordW-1:0]  message_word_i,
  input  logic [sip24_pkg::CountW-1:0] valid_bytes_i,
  input  logic                         last_word_i,
  input  logic [sip24_pkg::WordW-1:0]  key_low_i,
  input  logic [sip24_pkg::WordW-1:0]  key_high_i,
  output logic                         fin_valid_o,
  input  logic                         fin_ready_i,
  output sip24_pkg::fin_t              fin_o
);
  import sip24_pkg::*;

  logic              iv_q;
  logic [WordW-1:0]  word_q;
  logic [CountW-1:0] count_q;
  logic              last_q;

  lanes_t            lanes_q;
  logic [LenW-1:0]   len_q;
  logic              in_msg_q;

  lanes_t            base;
  lanes_t            after;
  logic [LenW-1:0]   len_base;
  logic [LenW-1:0]   len_new;
  logic [WordW-1:0]  block;
  logic              full;
  logic              go;

  // A count of 8 or more is a full word.
  assign full = count_q[CountW-1];
  assign go   = iv_q && (!last_q || fin_ready_i);
  assign in_ready_o = !iv_q || go;

  always_comb begin
    if (in_msg_q) begin
      base     = lanes_q;
      len_base = len_q;
    end else begin
      base.a   = key_low_i  ^ IV_A;
      base.b   = key_high_i ^ IV_B;
      base.c   = key_low_i  ^ IV_C;
      base.d   = key_high_i ^ IV_D;
      len_base = '0;
    end

    if (last_q && !full) begin
      len_new = len_base + LenW'(count_q[CountW-2:0]);
      block   = '0;
      for (int i = 0; i < 8; i++) begin
        if (i < int'(count_q[CountW-2:0])) block[8*i +: 8] = word_q[8*i +: 8];
      end
      block[WordW-1 -: LenW] = len_new;
    end else begin
      len_new = len_base + LenW'(8);
      block   = word_q;
    end

    after = sip_absorb(base, block);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q     <= 1'b0;
      in_msg_q <= 1'b0;
      len_q    <= '0;
    end else begin
      if (in_ready_o) begin
        iv_q <= in_valid_i;
      end
      if (go) begin
        in_msg_q <= !last_q;
        len_q    <= last_q ? '0 : len_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q  <= message_word_i;
      count_q <= valid_bytes_i;
      last_q  <= last_word_i;
    end
    if (go && !last_q) begin
      lanes_q <= after;
    end
  end

  assign fin_valid_o     = iv_q && last_q;
  assign fin_o.lanes     = after;
  assign fin_o.full_last = full;
  assign fin_o.len       = len_new;

endmodule

>>> rtl/sip24_final.sv
// Finalization pipeline: length block, 0xFF tweak, four rounds, lane fold.
module sip24_final (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fin_valid_i,
  output logic                        fin_ready_o,
  input  sip24_pkg::fin_t             fin_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sip24_pkg::WordW-1:0] hash_value_o
);
  import sip24_pkg::*;

  logic   v1_q, v2_q, v3_q, ov_q;
  fin_t   s1_q;
  lanes_t s2_q, s3_q;
  logic [WordW-1:0] hash_q;

  logic   r1, r2, r3, ro;
  lanes_t s1_res, s2_res, s3_res;
  logic [WordW-1:0] fold;

  assign ro = !ov_q || out_ready_i;
  assign r3 = !v3_q || ro;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign fin_ready_o = r1;

  always_comb begin
    // A full last word still owes the length-only block.
    if (s1_q.full_last) begin
      s1_res = sip_absorb(s1_q.lanes, {s1_q.len, {(WordW-LenW){1'b0}}});
    end else begin
      s1_res = s1_q.lanes;
    end

    s2_res   = s2_q;
    s2_res.c = s2_res.c ^ FIN_XOR;
    s2_res   = sip_round(s2_res);
    s2_res   = sip_round(s2_res);

    s3_res = sip_round(s3_q);
    s3_res = sip_round(s3_res);
    fold   = s3_res.a ^ s3_res.b ^ s3_res.c ^ s3_res.d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (r1) v1_q <= fin_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (ro) ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && fin_valid_i) s1_q   <= fin_i;
    if (r2 && v1_q)        s2_q   <= s1_res;
    if (r3 && v2_q)        s3_q   <= s2_res;
    if (ro && v3_q)        hash_q <= fold;
  end

  assign out_valid_o  = ov_q;
  assign hash_value_o = hash_q;

endmodule

>>> rtl/siphash_2_4_stream_core.sv
// Top level of the SipHash-2-4 stream core: key registers, absorb loop, finalization.
// Throughput: one message word per cycle unless a last word waits on finalization;
// the lane loop does two SipRounds per cycle. Path of a last word to the hash output:
// input register, absorb, length block, two stages of two rounds each, output register.
// Reset: asynchronous, active low; clears the keys, handshake state and message state.
module siphash_2_4_stream_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sip24_pkg::AddrW-1:0]  paddr,
  input  logic [sip24_pkg::WordW-1:0]  pwdata,
  output logic [sip24_pkg::WordW-1:0]  prdata,
  output logic                         pready,
  // Message words.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sip24_pkg::WordW-1:0]  message_word_i,
  input  logic [sip24_pkg::CountW-1:0] valid_bytes_i,
  input  logic                         last_word_i,
  // Hash results.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sip24_pkg::WordW-1:0]  hash_value_o
);
  import sip24_pkg::*;

  logic [WordW-1:0] key_low;
  logic [WordW-1:0] key_high;
  logic             fin_valid;
  logic             fin_ready;
  fin_t             fin;

  // The key registers are read when the first word of a message is absorbed.
  // A key written while a message is open therefore applies to the next one.
  sip24_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .key_low_o  (key_low),
    .key_high_o (key_high)
  );

  // Each word transaction lands in an input register. Words that are not last
  // are absorbed in the next cycle and only update the lane registers, so
  // they never wait on the finalization pipeline; a last word waits only when
  // the first finalization stage is full and cannot move.
  sip24_absorb u_absorb (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .message_word_i (message_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .last_word_i    (last_word_i),
    .key_low_i      (key_low),
    .key_high_i     (key_high),
    .fin_valid_o    (fin_valid),
    .fin_ready_i    (fin_ready),
    .fin_o          (fin)
  );

  // Finalization is a three-stage pipeline ending in an output register. Each
  // stage advances independently, so bubbles close up behind a stalled result
  // and new messages keep flowing while a hash waits to be taken, until the stages fill.
  sip24_final u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fin_valid_i  (fin_valid),
    .fin_ready_o  (fin_ready),
    .fin_i        (fin),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

endmodule

>>> sim/tb.sv
// Self-checking testbench for the SipHash-2-4 stream core.
module tb;

  // Clock period is 8; reset is asserted at time zero and released once.
  localparam int unsigned ResetCycles = 8;
  // Settle time after every expected hash has come out, with some slack.
  localparam int unsigned DrainCycles = 12;
  // Cycles without any transaction on any port before the run is declared hung.
  localparam int unsigned StallLimit  = 2000;
  // Random words per key setting; five settings give at least 450 words.
  localparam int unsigned PhaseWords  = 90;
  localparam int unsigned PhaseCount  = 5;

  // Initialization words of the scheme ("somepseudorandomlygeneratedbytes").
  localparam logic [63:0] InitA = 64'h736F6D6570736575;
  localparam logic [63:0] InitB = 64'h646F72616E646F6D;
  localparam logic [63:0] InitC = 64'h6C7967656E657261;
  localparam logic [63:0] InitD = 64'h7465646279746573;
  localparam logic [63:0] FinalXor = 64'h00000000000000FF;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [sip24_pkg::AddrW-1:0]  paddr   = '0;
  logic [sip24_pkg::WordW-1:0]  pwdata  = '0;
  logic [sip24_pkg::WordW-1:0]  prdata;
  logic                         pready;

  logic                         in_valid_i     = 1'b0;
  logic                         in_ready_o;
  logic [sip24_pkg::WordW-1:0]  message_word_i = '0;
  logic [sip24_pkg::CountW-1:0] valid_bytes_i  = '0;
  logic                         last_word_i    = 1'b0;

  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [sip24_pkg::WordW-1:0]  hash_value_o;

  always #4 clk_i = ~clk_i;

  siphash_2_4_stream_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .message_word_i (message_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .last_word_i    (last_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hash_value_o   (hash_value_o)
  );

  // ---------------------------------------------------------------------------
  // Hash predictor. It mirrors the key registers and keeps its own copy of the
  // four lanes, the running length and whether a message is open.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } lane_set_t;

  logic [63:0] key_low_copy  = '0;
  logic [63:0] key_high_copy = '0;
  lane_set_t   lanes_copy    = '0;
  logic [7:0]  length_copy   = '0;
  logic        open_copy     = 1'b0;

  function automatic logic [63:0] rotl64(logic [63:0] x, int unsigned n);
    return (x << n) | (x >> (64 - n));
  endfunction

  // One SipRound: add, rotate, xor on both halves, then the cross mix.
  function automatic lane_set_t mix_lanes(lane_set_t s);
    s.a = s.a + s.b;  s.b = rotl64(s.b, 13);
    s.b = s.b ^ s.a;  s.a = rotl64(s.a, 32);
    s.c = s.c + s.d;  s.d = rotl64(s.d, 16);
    s.d = s.d ^ s.c;
    s.a = s.a + s.d;  s.d = rotl64(s.d, 21);
    s.d = s.d ^ s.a;
    s.c = s.c + s.b;  s.b = rotl64(s.b, 17);
    s.b = s.b ^ s.c;  s.c = rotl64(s.c, 32);
    return s;
  endfunction

  // Absorbing a block: xor into lane d, two rounds, xor into lane a.
  function automatic lane_set_t fold_block(lane_set_t s, logic [63:0] m);
    s.d = s.d ^ m;
    s = mix_lanes(s);
    s = mix_lanes(s);
    s.a = s.a ^ m;
    return s;
  endfunction

  // Advances the predicted state by one accepted word. When the word closes the
  // message, done is set and hash holds the expected digest.
  task automatic predict_hash(input logic [63:0] word, input logic [3:0] count,
                              input logic last_w, output logic done,
                              output logic [63:0] hash);
    logic [3:0]  used;
    logic [63:0] block;
    done = 1'b0;
    hash = '0;
    if (!open_copy) begin
      // A new message picks up whatever key is in the registers right now.
      lanes_copy.a = key_low_copy  ^ InitA;
      lanes_copy.b = key_high_copy ^ InitB;
      lanes_copy.c = key_low_copy  ^ InitC;
      lanes_copy.d = key_high_copy ^ InitD;
      length_copy  = '0;
      open_copy    = 1'b1;
    end
    if (!last_w) begin
      // Words before the last always count as eight bytes.
      lanes_copy  = fold_block(lanes_copy, word);
      length_copy = length_copy + 8'd8;
    end else begin
      used = (count > 4'd8) ? 4'd8 : count;
      if (used == 4'd8) begin
        lanes_copy  = fold_block(lanes_copy, word);
        length_copy = length_copy + 8'd8;
        block       = '0;
      end else begin
        length_copy = length_copy + 8'(used);
        block = (used == 4'd0) ? 64'h0 : (word & ((64'h1 << (8 * used)) - 64'h1));
      end
      block[63:56] = length_copy;
      lanes_copy   = fold_block(lanes_copy, block);
      lanes_copy.c = lanes_copy.c ^ FinalXor;
      repeat (4) lanes_copy = mix_lanes(lanes_copy);
      hash        = lanes_copy.a ^ lanes_copy.b ^ lanes_copy.c ^ lanes_copy.d;
      done        = 1'b1;
      open_copy   = 1'b0;
      length_copy = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Bookkeeping shared by the driver, the monitor and the summary.
  // ---------------------------------------------------------------------------
  logic [63:0] expected_hashes[$];
  int unsigned mismatches     = 0;
  int unsigned words_accepted = 0;
  int unsigned messages_ended = 0;
  int unsigned hashes_checked = 0;
  int unsigned key_writes     = 0;
  int unsigned longest_words  = 0;
  int unsigned odd_counts     = 0;
  int unsigned drain_pauses   = 0;
  bit          tx_calm        = 1'b0;
  bit          rx_calm        = 1'b0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Directed stimulus. Key rows program a register; word rows send one input
  // transaction. Rows marked known carry a published SipHash-2-4 value for the
  // key 00..0f; all other word rows are checked against the predictor.
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {ROW_WORD, ROW_KEY_LOW, ROW_KEY_HIGH} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        known;
    logic [63:0] hash;
  } plan_row_t;

  localparam int PlanRows = 21;

  plan_row_t directed_plan [PlanRows] = '{
    // Zero key straight out of reset: empty message, then a full last word.
    '{ROW_WORD,     64'h0000000000000000, 4'd0,  1'b1, 1'b0, 64'h0},
    '{ROW_WORD,     64'hFFFFFFFFFFFFFFFF, 4'd8,  1'b1, 1'b0, 64'h0},
    // A short count before the last word still counts as eight bytes; the
    // bytes above the count of the last word must be dropped.
    '{ROW_WORD,     64'h123456789ABCDEF0, 4'd3,  1'b0, 1'b0, 64'h0},
    '{ROW_WORD,     64'hFFFFFFFFFFFFFFFF, 4'd5,  1'b1, 1'b0, 64'h0},
    // Key 00..0f with the published vectors for the empty and 15-byte message.
    '{ROW_KEY_LOW,  64'h0706050403020100, 4'd0,  1'b0, 1'b0, 64'h0},
    '{ROW_KEY_HIGH, 64'h0F0E0D0C0B0A0908, 4'd0,  1'b0, 1'b0, 64'h0},
    '{ROW_WORD,     64'h0000000000000000, 4'd0,  1'b1, 1'b1, 64'h726FDB47DD0E0E31},
    '{ROW_WORD,     64'h0706050403020100, 4'd8,  1'b0, 1'b0, 64'h0},
    '{ROW_WORD,     64'hFF0E0D0C0B0A0908, 4'd7,  1'b1, 1'b1, 64'hA129CA6149BE45E5},
    // Counts above eight on a last word behave like eight.
    '{ROW_WORD,     64'h0000000000000000, 4'd15, 1'b1, 1'b0, 64'h0},
    '{ROW_WORD,     64'hA5A5A5A5A5A5A5A5, 4'd9,  1'b1, 1'b0, 64'h0},
    '{ROW_WORD,     64'h0000000000000000, 4'd0,  1'b0, 1'b0, 64'h0},
    '{ROW_WORD,     64'hFFFFFFFFFFFFFFFF, 4'd1,  1'b1, 1'b0, 64'h0},
    // All-ones key.
    '{ROW_KEY_LOW,  64'hFFFFFFFFFFFFFFFF, 4'd0,  1'b0, 1'b0, 64'h0},
    '{ROW_KEY_HIGH, 64'hFFFFFFFFFFFFFFFF, 4'd0,  1'b0, 1'b0, 64'h0},
    '{ROW_WORD,     64'hFFFFFFFFFFFFFFFF, 4'd8,  1'b0, 1'b0, 64'h0},
    '{ROW_WORD,     64'h0000000000000000, 4'd8,  1'b1, 1'b0, 64'h0},
    '{ROW_WORD,     64'h8000000000000001, 4'd4,  1'b1, 1'b0, 64'h0},
    '{ROW_WORD,     64'h0000000000000000, 4'd2,  1'b0, 1'b0, 64'h0},
    '{ROW_WORD,     64'h0102030405060708, 4'd6,  1'b1, 1'b0, 64'h0},
    '{ROW_WORD,     64'h7F7F7F7F7F7F7F7F, 4'd14, 1'b1, 1'b0, 64'h0}
  };

  // ---------------------------------------------------------------------------
  // Message driver. Valid is only lowered when a gap follows, so back-to-back
  // transactions never see two assignments to valid in one time step.
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [63:0] word, input logic [3:0] count,
                           input logic last_w, input logic known,
                           input logic [63:0] known_hash);
    int unsigned gap;
    logic        done;
    logic [63:0] hash;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    message_word_i <= word;
    valid_bytes_i  <= count;
    last_word_i    <= last_w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // The transaction completed at this edge.
    words_accepted++;
    predict_hash(word, count, last_w, done, hash);
    if (done) begin
      messages_ended++;
      expected_hashes.push_back(known ? known_hash : hash);
    end
  endtask

  // Holds off the sender until every expected hash has come out, then waits
  // out the settle time so the core is truly idle.
  task automatic quiesce(input int unsigned settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_hashes.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // Register write over the configuration port: setup cycle, then access
  // cycle. The key copy is updated at the edge where the write lands.
  task automatic write_key(input logic reg_idx, input logic [63:0] value);
    quiesce(DrainCycles);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sip24_pkg::AddrW'({reg_idx, 3'b000});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (reg_idx == sip24_pkg::REG_KEY_LOW) key_low_copy = value;
    else key_high_copy = value;
    key_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random 64-bit values with extra weight on all-zeros and all-ones.
  function automatic logic [63:0] draw_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 64'h0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // One well-formed message of random content. Most are short; about one in
  // ten runs past 32 words so the length byte wraps. A few words carry odd
  // byte counts: short counts before the last word and counts above eight.
  task automatic send_random_message(output int unsigned sent);
    int unsigned n;
    logic [3:0]  count;
    logic        last_w;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 6);
    if (n > longest_words) longest_words = n;
    if ($urandom_range(0, 5) == 0) tx_calm = !tx_calm;
    for (int unsigned i = 0; i < n; i++) begin
      last_w = (i == n - 1);
      if (!last_w) begin
        count = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
      end else begin
        count = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
      end
      if ((!last_w && count != 4'd8) || count > 4'd8) odd_counts++;
      push_word(draw_word(), count, last_w, 1'b0, 64'h0);
    end
    sent = n;
  endtask

  // ---------------------------------------------------------------------------
  // Hash receiver. Before each result it may hold ready low, except in
  // calm stretches where ready stays high.
  // ---------------------------------------------------------------------------
  initial begin : hash_sink
    int unsigned stall;
    forever begin
      if ($urandom_range(0, 7) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Result checker: each hash transaction is compared with the oldest
  // expectation. Everything is sampled at the rising edge, before the
  // nonblocking updates of that edge land.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch($sformatf("hash %h with nothing expected", hash_value_o));
      end else begin
        hashes_checked++;
        if (hash_value_o !== expected_hashes[0]) begin
          report_mismatch($sformatf("hash_value got %h want %h",
                                    hash_value_o, expected_hashes[0]));
        end
        void'(expected_hashes.pop_front());
      end
    end
  end

  // Watchdog: fails and ends the run once no transaction of any kind has
  // happened for as long as StallLimit allows.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable) ||
          !rst_ni) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no transaction for %0d cycles", StallLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, then random phases under several keys.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase_words;
    int unsigned sent;
    logic [63:0] key_lo;
    logic [63:0] key_hi;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[r]) begin
      case (directed_plan[r].kind)
        ROW_KEY_LOW: begin
          write_key(sip24_pkg::REG_KEY_LOW, directed_plan[r].data);
        end
        ROW_KEY_HIGH: begin
          write_key(sip24_pkg::REG_KEY_HIGH, directed_plan[r].data);
        end
        default: begin
          push_word(directed_plan[r].data, directed_plan[r].count, directed_plan[r].last,
                    directed_plan[r].known, directed_plan[r].hash);
        end
      endcase
    end

    // Each phase reprograms both key halves; the second and third phases pin
    // one half to all-ones and the other to zero, the rest are random.
    for (int unsigned p = 0; p < PhaseCount; p++) begin
      case (p)
        1:       begin key_lo = '1;          key_hi = '0;          end
        2:       begin key_lo = '0;          key_hi = '1;          end
        default: begin key_lo = draw_word(); key_hi = draw_word(); end
      endcase
      write_key(sip24_pkg::REG_KEY_LOW, key_lo);
      write_key(sip24_pkg::REG_KEY_HIGH, key_hi);
      phase_words = 0;
      while (phase_words < PhaseWords) begin
        send_random_message(sent);
        phase_words += sent;
        // Now and then the sender waits for the pipeline to empty completely.
        if ($urandom_range(0, 9) == 0 || (p == 0 && drain_pauses == 0)) begin
          drain_pauses++;
          quiesce(0);
        end
      end
    end

    // Let the last hashes come out, then watch for strays over the latency.
    quiesce(DrainCycles);
    if (expected_hashes.size() != 0) begin
      report_mismatch($sformatf("%0d hashes never produced", expected_hashes.size()));
    end

    $display("covered %0d words in %0d messages (longest %0d words), %0d odd byte counts",
             words_accepted, messages_ended, longest_words, odd_counts);
    $display("checked %0d hashes over %0d key writes, %0d full drains, %0d mismatches",
             hashes_checked, key_writes, drain_pauses, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sip24_pkg.sv
rtl/sip24_cfg.sv
rtl/sip24_absorb.sv
rtl/sip24_final.sv
rtl/siphash_2_4_stream_core.sv
sim/tb.sv
